/* hw/rtl/csvt_pkg.sv */
// Package with the character codes and the state and result types of the CSV tokenizer.
`default_nettype none

package csvt_pkg;

	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_NUL   = 8'd0;

	typedef struct packed {
		logic [7:0] pending_byte;
		logic       pending_valid;
		logic       inside_quotes;
		logic       quote_run_parity;
		logic       previous_was_quote;
		logic       field_has_chars;
		logic       row_has_fields;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_field;
		logic       end_of_row;
		logic       no_row;
		logic       bad_delimiter;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/csvt_parse_core.sv */
// Parse state registers and the per-byte next-state and result logic.
`default_nettype none

module csvt_parse_core import csvt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] delimiter_char,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output result_t         res,
	output logic            res_valid
);

	parse_state_t st_q;
	parse_state_t st_nxt;
	logic [7:0]   ch;
	logic         bad_delim;
	logic         parity;
	logic         replace;
	logic         hb;

	assign bad_delim = (delimiter_char == CH_NL) || (delimiter_char == CH_CR) ||
		(delimiter_char == CH_NUL) || (delimiter_char == CH_QUOTE);

	always_comb begin
		st_nxt    = st_q;
		res       = '0;
		res_valid = 1'b0;
		ch        = end_of_input ? CH_NL : in_byte;
		parity    = st_q.quote_run_parity;
		replace   = 1'b0;
		hb        = 1'b0;
		if (bad_delim) begin
			res.bad_delimiter = 1'b1;
			res_valid         = 1'b1;
		end else if (end_of_input && !st_q.field_has_chars && !st_q.row_has_fields) begin
			st_nxt     = '0;
			res.no_row = 1'b1;
			res_valid  = 1'b1;
		end else if (!end_of_input && (in_byte == CH_CR)) begin
			// Carriage returns are dropped without touching the state.
			st_nxt = st_q;
		end else if (!st_q.field_has_chars && !st_q.previous_was_quote && (ch == CH_QUOTE)) begin
			// Opening quote of a field.
			st_nxt.inside_quotes      = 1'b1;
			st_nxt.previous_was_quote = 1'b1;
		end else begin
			if (st_q.field_has_chars || st_q.previous_was_quote) begin
				if (ch == CH_QUOTE) begin
					parity                  = !st_q.quote_run_parity;
					st_nxt.quote_run_parity = parity;
					st_nxt.inside_quotes    = !parity;
					replace                 = !parity;
				end else begin
					st_nxt.quote_run_parity = 1'b0;
				end
			end
			if (end_of_input || (((ch == delimiter_char) || (ch == CH_NL)) &&
					!st_nxt.inside_quotes)) begin
				hb               = !st_q.previous_was_quote && st_q.pending_valid;
				res.out_byte     = hb ? st_q.pending_byte : 8'd0;
				res.has_byte     = hb;
				res.end_of_field = 1'b1;
				res.end_of_row   = (ch == CH_NL);
				res_valid        = 1'b1;
				if (ch == CH_NL) begin
					st_nxt = '0;
				end else begin
					// The quote run parity carries over into the next field.
					st_nxt.pending_byte       = 8'd0;
					st_nxt.pending_valid      = 1'b0;
					st_nxt.field_has_chars    = 1'b0;
					st_nxt.inside_quotes      = 1'b0;
					st_nxt.previous_was_quote = 1'b0;
					st_nxt.row_has_fields     = 1'b1;
				end
			end else if (replace) begin
				// Second quote of a doubled pair takes the place of the first.
				st_nxt.pending_byte       = ch;
				st_nxt.previous_was_quote = 1'b1;
			end else begin
				res.out_byte              = st_q.pending_byte;
				res.has_byte              = 1'b1;
				res_valid                 = st_q.pending_valid;
				st_nxt.pending_byte       = ch;
				st_nxt.pending_valid      = 1'b1;
				st_nxt.field_has_chars    = 1'b1;
				st_nxt.previous_was_quote = (ch == CH_QUOTE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer: input register, parse core and result register.
// An accepted byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle unless stalled; carriage returns and held-back bytes give no result.
// A stalled output holds the result register, and stalls the input while the input register is full.
// Reset is asynchronous and active low: it empties both registers, clears the parse state
// and sets the delimiter to a comma.
`default_nettype none

module csv_field_tokenizer import csvt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       delimiter_we,
	input  wire logic [7:0] delimiter_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            end_of_field,
	output logic            end_of_row,
	output logic            no_row,
	output logic            bad_delimiter
);

	logic [7:0] delimiter_q;
	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       end_of_input_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	logic       res_valid;
	logic       out_free;
	logic       advance;
	logic       accept;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= CH_COMMA;
		end else if (delimiter_we) begin
			delimiter_q <= delimiter_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_byte_s1      <= in_byte;
			end_of_input_s1 <= end_of_input;
		end
	end

	csvt_parse_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.delimiter_char (delimiter_q),
		.in_byte        (in_byte_s1),
		.end_of_input   (end_of_input_s1),
		.res            (res),
		.res_valid      (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = res_q.out_byte;
	assign has_byte      = res_q.has_byte;
	assign end_of_field  = res_q.end_of_field;
	assign end_of_row    = res_q.end_of_row;
	assign no_row        = res_q.no_row;
	assign bad_delimiter = res_q.bad_delimiter;

	// A row always closes on a field boundary.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_row |-> end_of_field)
		else $error("end of row without end of field");

	// An error or no-row transaction carries nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bad_delimiter || no_row) |-> !has_byte && !end_of_field && !end_of_row)
		else $error("status transaction carries field data");

	// A transaction without a byte shows a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_byte == 8'd0)
		else $error("nonzero byte without has_byte");

	// The input stalls only while a byte waits in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with empty input register");

endmodule

`default_nettype wire

/* tb/sv/csv_field_tokenizer_tb.sv */
// Self-checking testbench of the CSV field tokenizer with a built-in behavioral predictor.
module csv_field_tokenizer_tb import csvt_pkg::*; ();

	localparam logic [7:0] CH_TAB = 8'd9;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       delimiter_we;
	logic [7:0] delimiter_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_input;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_field;
	logic       end_of_row;
	logic       no_row;
	logic       bad_delimiter;

	parse_state_t shadow_state;
	logic [7:0]   shadow_delim;
	result_t      expected_tokens[$];
	int           errors = 0;
	int           items_sent = 0;
	bit           idle_on = 1'b0;
	bit           hold_request = 1'b0;

	csv_field_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.delimiter_we(delimiter_we),
		.delimiter_wdata(delimiter_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.end_of_field(end_of_field),
		.end_of_row(end_of_row),
		.no_row(no_row),
		.bad_delimiter(bad_delimiter)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	// Advances the shadow parser by one byte and queues the token it emits, if any.
	function void predict_tokens(input logic [7:0] c, input logic eoi);
		result_t    r;
		logic [7:0] ch;
		logic       replace;
		r = '0;
		ch = c;
		replace = 1'b0;
		if (shadow_delim == CH_NL || shadow_delim == CH_CR || shadow_delim == CH_NUL ||
				shadow_delim == CH_QUOTE) begin
			r.bad_delimiter = 1'b1;
			expected_tokens.push_back(r);
			return;
		end
		if (eoi) begin
			if (!shadow_state.field_has_chars && !shadow_state.row_has_fields) begin
				shadow_state = '0;
				r.no_row = 1'b1;
				expected_tokens.push_back(r);
				return;
			end
			ch = CH_NL;
		end else if (ch == CH_CR) begin
			return;
		end

		if (!shadow_state.field_has_chars && !shadow_state.previous_was_quote) begin
			if (ch == CH_QUOTE) begin
				shadow_state.inside_quotes = 1'b1;
				shadow_state.previous_was_quote = 1'b1;
				return;
			end
		end else if (ch == CH_QUOTE) begin
			shadow_state.quote_run_parity = !shadow_state.quote_run_parity;
			shadow_state.inside_quotes = !shadow_state.quote_run_parity;
			replace = shadow_state.inside_quotes;
		end else begin
			shadow_state.quote_run_parity = 1'b0;
		end

		if (eoi || ((ch == shadow_delim || ch == CH_NL) && !shadow_state.inside_quotes)) begin
			r.has_byte = shadow_state.previous_was_quote ? 1'b0 : shadow_state.pending_valid;
			r.out_byte = r.has_byte ? shadow_state.pending_byte : 8'd0;
			r.end_of_field = 1'b1;
			r.end_of_row = (ch == CH_NL);
			expected_tokens.push_back(r);
			if (r.end_of_row) begin
				shadow_state = '0;
			end else begin
				shadow_state.pending_byte = 8'd0;
				shadow_state.pending_valid = 1'b0;
				shadow_state.field_has_chars = 1'b0;
				shadow_state.inside_quotes = 1'b0;
				shadow_state.previous_was_quote = 1'b0;
				shadow_state.row_has_fields = 1'b1;
			end
			return;
		end

		// The second quote of a doubled pair takes the place of the held quote.
		if (replace) begin
			shadow_state.pending_byte = ch;
			shadow_state.previous_was_quote = 1'b1;
			return;
		end
		if (shadow_state.pending_valid) begin
			r.out_byte = shadow_state.pending_byte;
			r.has_byte = 1'b1;
			expected_tokens.push_back(r);
		end
		shadow_state.pending_byte = ch;
		shadow_state.pending_valid = 1'b1;
		shadow_state.field_has_chars = 1'b1;
		shadow_state.previous_was_quote = (ch == CH_QUOTE);
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task send_item(input logic [7:0] b, input logic eoi);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_tokens(b, eoi);
		if (eoi || b != CH_CR)
			items_sent++;
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_byte, has_byte, end_of_field, end_of_row, no_row, bad_delimiter};
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token: byte %0d has %b eof %b eor %b nr %b bd %b",
					$time, got.out_byte, got.has_byte, got.end_of_field, got.end_of_row,
					got.no_row, got.bad_delimiter);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want) begin
					$display("%0t: expected byte %0d has %b eof %b eor %b nr %b bd %b", $time,
						want.out_byte, want.has_byte, want.end_of_field, want.end_of_row,
						want.no_row, want.bad_delimiter);
					$display("%0t: actual   byte %0d has %b eof %b eor %b nr %b bd %b", $time,
						got.out_byte, got.has_byte, got.end_of_field, got.end_of_row,
						got.no_row, got.bad_delimiter);
					errors++;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task drain;
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		// Carriage returns and held bytes may still be inside the pipeline.
		repeat (6) @(posedge clk);
	endtask

	task write_delimiter(input logic [7:0] d);
		drain();
		delimiter_we <= 1'b1;
		delimiter_wdata <= d;
		@(posedge clk);
		delimiter_we <= 1'b0;
		shadow_delim = d;
	endtask

	function logic [7:0] plain_char(input logic [7:0] d);
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		// Occasionally a raw byte, which may be a control character.
		if ($urandom_range(0, 9) == 0)
			return c;
		while (c == d || c == CH_QUOTE || c == CH_NL || c == CH_CR)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task send_field(input logic [7:0] d, input bit quoted);
		int n;
		int k;
		if (quoted) begin
			send_item(CH_QUOTE, 1'b0);
			n = $urandom_range(0, 5);
			for (int i = 0; i < n; i++) begin
				k = $urandom_range(0, 9);
				if (k == 0) begin
					send_item(CH_QUOTE, 1'b0);
					send_item(CH_QUOTE, 1'b0);
				end else if (k == 1) begin
					send_item(d, 1'b0);
				end else if (k == 2) begin
					send_item(CH_NL, 1'b0);
				end else if (k == 3) begin
					send_item(CH_CR, 1'b0);
				end else begin
					send_item(plain_char(d), 1'b0);
				end
			end
			// Sometimes the closing quote is left out.
			if ($urandom_range(0, 7) != 0)
				send_item(CH_QUOTE, 1'b0);
		end else begin
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				send_item(plain_char(d), 1'b0);
		end
	endtask

	task send_rows(input int count, input logic [7:0] d);
		int target;
		int nf;
		int k;
		target = items_sent + count;
		while (items_sent < target) begin
			nf = $urandom_range(1, 4);
			for (int f = 0; f < nf; f++) begin
				send_field(d, $urandom_range(0, 2) == 0);
				if (f != nf - 1)
					send_item(d, 1'b0);
			end
			k = $urandom_range(0, 9);
			if (k == 0) begin
				send_item(CH_CR, 1'b0);
				send_item(CH_NL, 1'b0);
			end else if (k == 1) begin
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end else if (k == 2) begin
				send_item(8'($urandom_range(0, 255)), 1'b1);
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end else if (k == 3) begin
				repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
				send_item(CH_NL, 1'b0);
			end else begin
				send_item(CH_NL, 1'b0);
			end
		end
	endtask

	task test_directed;
		// End of input with nothing pending.
		send_item(8'hFF, 1'b1);
		// A plain row.
		send_item("a", 1'b0);
		send_item(CH_COMMA, 1'b0);
		send_item("b", 1'b0);
		send_item(CH_NL, 1'b0);
		// A lone opening quote before end of input.
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h00, 1'b1);
		// Quoted field with a doubled quote, closed by a delimiter.
		send_item(CH_QUOTE, 1'b0);
		send_item("x", 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item("y", 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(CH_COMMA, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(CH_NL, 1'b0);
		// Empty fields.
		send_item(CH_COMMA, 1'b0);
		send_item(CH_NL, 1'b0);
		// A field that ends at end of input right after its opening quote.
		send_item("a", 1'b0);
		send_item(CH_COMMA, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(8'hFF, 1'b1);
	endtask

	task test_delimiters;
		logic [7:0] good[3];
		logic [7:0] bad[4];
		good = '{8'hFF, CH_TAB, CH_COMMA};
		bad = '{CH_NUL, CH_QUOTE, CH_NL, CH_CR};
		foreach (bad[i]) begin
			write_delimiter(bad[i]);
			repeat (5) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		foreach (good[i]) begin
			write_delimiter(good[i]);
			send_rows(60, good[i]);
			send_item(8'h00, 1'b1);
		end
	endtask

	task test_backpressure;
		drain();
		idle_on = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(plain_char(shadow_delim), i % 8 == 7);
	endtask

	task test_random;
		idle_on = 1'b1;
		send_rows(300, shadow_delim);
		// The closing stretch runs with no idling on either side.
		idle_on = 1'b0;
		send_rows(100, shadow_delim);
	endtask

	initial begin
		shadow_state = '0;
		shadow_delim = CH_COMMA;
		arst_n <= 1'b0;
		delimiter_we <= 1'b0;
		delimiter_wdata <= 8'd0;
		in_valid <= 1'b0;
		in_byte <= 8'd0;
		end_of_input <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		test_directed();
		test_delimiters();
		test_backpressure();
		test_random();

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
